>>> rtl/core/sensor_scratchpad_crc_checker_core_assert.svh
// Assertion macros for the sensor scratchpad CRC checker.
// Used by sscc_frame_check in rtl/core; expects i_clk and i_rst_n in scope.
`ifndef SENSOR_SCRATCHPAD_CRC_CHECKER_CORE_ASSERT_SVH
`define SENSOR_SCRATCHPAD_CRC_CHECKER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SSCC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SSCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/sscc_pkg.sv
// Shared types, constants and the CRC-8 byte update for the scratchpad checker.
// No dependencies; imported by every module in rtl/core.
package sscc_pkg;

    localparam logic [7:0] SENSOR_FAMILY = 8'h28;
    localparam logic [7:0] CRC_POLY      = 8'h8C;
    localparam int         FRAME_BYTES   = 9;
    localparam int         CRC_BYTES     = 8;
    localparam logic [3:0] LAST_POS      = 4'(FRAME_BYTES - 1);

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_CRC_ERR   = 2'd1,
        ST_WRONG_FAM = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
        logic [7:0] dev_family;
    } t_item;

    // Reflected CRC-8, one byte, LSB first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic [7:0] d;
        logic       mix;
        c = crc;
        d = b;
        for (int k = 0; k < 8; k++) begin
            mix = c[0] ^ d[0];
            c   = {1'b0, c[7:1]};
            if (mix) begin
                c = c ^ CRC_POLY;
            end
            d   = {1'b0, d[7:1]};
        end
        return c;
    endfunction

endpackage

>>> rtl/core/sscc_in_reg.sv
// Input register stage of the scratchpad checker.
// Depends on sscc_pkg for the request type.
module sscc_in_reg
    import sscc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_take
);

    logic  r_vld;
    logic  n_vld;
    t_item r_item;
    logic  accept;

    // Hold while the stored request is not taken downstream.
    assign o_stall = r_vld && !i_take;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_vld = r_vld;
        if (accept) begin
            n_vld = 1'b1;
        end else if (i_take) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_vld;
    assign o_item  = r_item;

endmodule

>>> rtl/core/sscc_frame_check.sv
// Frame tracking, CRC update and result register of the scratchpad checker.
// Depends on sscc_pkg and the assertion macro header.
`include "sensor_scratchpad_crc_checker_core_assert.svh"

module sscc_frame_check
    import sscc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_item              i_item,
    output logic               o_take,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_status            o_status,
    output logic signed [15:0] o_temp
);

    logic               r_ignored;
    logic [3:0]         r_byte_pos;
    logic [7:0]         r_crc;
    logic [7:0]         r_temp_lo;
    logic [7:0]         r_temp_hi;
    logic               r_out_vld;
    t_status            r_status;
    logic signed [15:0] r_temp;

    logic               n_ignored;
    logic [3:0]         n_byte_pos;
    logic [7:0]         n_crc;
    logic [7:0]         n_temp_lo;
    logic [7:0]         n_temp_hi;
    logic               n_out_vld;

    logic               out_free;
    logic               fire;
    logic               res_vld;
    t_status            res_status;
    logic signed [15:0] res_temp;
    logic [3:0]         eff_pos;
    logic [7:0]         eff_crc;
    logic               active;

    assign out_free = !r_out_vld || !i_out_stall;
    assign fire     = i_valid && out_free;
    assign o_take   = fire;

    // A start byte restarts position and CRC.
    assign eff_pos = i_item.frame_start ? 4'd0 : r_byte_pos;
    assign eff_crc = i_item.frame_start ? 8'd0 : r_crc;

    always_comb begin
        n_ignored  = r_ignored;
        n_byte_pos = r_byte_pos;
        n_crc      = r_crc;
        n_temp_lo  = r_temp_lo;
        n_temp_hi  = r_temp_hi;
        res_vld    = 1'b0;
        res_status = ST_OK;
        res_temp   = '0;
        active     = 1'b0;
        if (fire) begin
            if (i_item.frame_start) begin
                if (i_item.dev_family != SENSOR_FAMILY) begin
                    n_ignored  = 1'b1;
                    res_vld    = 1'b1;
                    res_status = ST_WRONG_FAM;
                end else begin
                    n_ignored = 1'b0;
                    active    = 1'b1;
                end
            end else begin
                active = !r_ignored;
            end
        end
        if (active) begin
            if (eff_pos < 4'(CRC_BYTES)) begin
                n_crc      = crc8_byte(eff_crc, i_item.data_byte);
                n_byte_pos = eff_pos + 4'd1;
                if (eff_pos == 4'd0) begin
                    n_temp_lo = i_item.data_byte;
                end else if (eff_pos == 4'd1) begin
                    n_temp_hi = i_item.data_byte;
                end
            end else begin
                // Last byte: close the frame and check.
                n_ignored  = 1'b1;
                n_byte_pos = LAST_POS;
                res_vld    = 1'b1;
                if (eff_crc != i_item.data_byte) begin
                    res_status = ST_CRC_ERR;
                end else begin
                    res_temp = {r_temp_hi, r_temp_lo};
                end
            end
        end
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (fire) begin
            n_out_vld = res_vld;
        end else if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ignored  <= 1'b1;
            r_byte_pos <= 4'd0;
            r_crc      <= 8'd0;
            r_temp_lo  <= 8'd0;
            r_temp_hi  <= 8'd0;
            r_out_vld  <= 1'b0;
        end else begin
            r_ignored  <= n_ignored;
            r_byte_pos <= n_byte_pos;
            r_crc      <= n_crc;
            r_temp_lo  <= n_temp_lo;
            r_temp_hi  <= n_temp_hi;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && res_vld) begin
            r_status <= res_status;
            r_temp   <= res_temp;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_status    = r_status;
    assign o_temp      = r_temp;

    `SSCC_ASSERT_NOW(a_pos_range, 1'b1, r_byte_pos <= LAST_POS,
        "byte position past the last frame byte")
    `SSCC_ASSERT_NOW(a_bad_temp_zero, r_out_vld && r_status != ST_OK, r_temp == 16'sd0,
        "non-ok result carries a temperature")
    `SSCC_ASSERT_NEXT(a_result_closes, fire && res_vld, r_ignored && r_out_vld,
        "result issued without closing the frame")
    `SSCC_ASSERT_NEXT(a_idle_drop, fire && !i_item.frame_start && r_ignored,
        $stable(r_crc) && $stable(r_byte_pos) && $stable(r_temp_lo) && $stable(r_temp_hi),
        "dropped byte changed frame state")

endmodule

>>> rtl/core/sensor_scratchpad_crc_checker_core.sv
// Top level of the sensor scratchpad CRC checker.
// Depends on sscc_pkg, sscc_in_reg and sscc_frame_check.
//
// Checks one temperature-sensor scratchpad frame of nine bytes, one byte per
// request. A start byte with a family code other than 0x28 gives a
// wrong-family result at once; otherwise the reflected CRC-8 (0x8C) runs over
// bytes 0 to 7 and byte 8 is compared, giving CRC error or OK with the raw
// signed temperature in 1/16 degree from bytes 1 and 0. One request is taken
// every cycle unless the result register is stalled. A request waits in the
// input register, then the combinational byte CRC update feeds the result
// register. Stall on a full result register holds both stages.
module sensor_scratchpad_crc_checker_core
    import sscc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_frame_start,
    input  logic [7:0]         i_dev_family,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic signed [15:0] o_temperature_sixteenths
);

    t_item   in_item;
    t_item   reg_item;
    logic    reg_valid;
    logic    take;
    t_status status;

    assign in_item.data_byte   = i_data_byte;
    assign in_item.frame_start = i_frame_start;
    assign in_item.dev_family  = i_dev_family;

    sscc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (in_item),
        .o_valid (reg_valid),
        .o_item  (reg_item),
        .i_take  (take)
    );

    sscc_frame_check u_frame_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (reg_valid),
        .i_item      (reg_item),
        .o_take      (take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_temp      (o_temperature_sixteenths)
    );

    assign o_status = status;

endmodule
